// ===== hw/rtl/sorted_insert_stack_assert.svh =====
// Assertion macros used by the checker module of the sorted insert stack.
`ifndef SORTED_INSERT_STACK_ASSERT_SVH
`define SORTED_INSERT_STACK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SIS_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("sorted_insert_stack: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SIS_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("sorted_insert_stack: next-cycle check failed");

`endif

// ===== hw/rtl/sis_pkg.sv =====
package sis_pkg;

   // Default number of entries in the store.
   localparam int CAPACITY_DEF = 16;

   // Field widths fixed by the request and response formats.
   localparam int VALUE_W  = 32;
   localparam int ACTION_W = 2;
   localparam int COUNT_W  = 5;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NOP  = 2'd3;

   // Value returned by pop or peek on an empty store.
   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

   // Control broadcast from the top level to every cell.
   typedef struct packed {
      logic                      push;
      logic                      pop;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/sis_if.sv =====
// Request channel: one operation on the store.
interface sis_req_if;
   logic                               valid;
   logic                               ready;
   logic [sis_pkg::ACTION_W-1:0]       action;
   logic signed [sis_pkg::VALUE_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

// Response channel: the outcome of one request.
interface sis_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [sis_pkg::VALUE_W-1:0] result_value;
   logic                               was_empty;
   logic                               dropped;
   logic [sis_pkg::COUNT_W-1:0]        entry_count;

   modport source (output valid, output result_value, output was_empty,
                   output dropped, output entry_count, input ready);
   modport sink   (input valid, input result_value, input was_empty,
                   input dropped, input entry_count, output ready);
endinterface

// ===== hw/rtl/sis_cell.sv =====
// One slot of the sorted chain. Slots ahead of the insert point keep their
// value, the slot at the insert point takes the new value, and slots behind
// it take their left neighbor's value. A pop shifts every slot one place up.
module sis_cell (
   input  logic                                 clock,
   input  sis_pkg::cell_ctl_type                ctl,
   input  logic                                 occupied,
   input  logic                                 left_gt,
   input  logic signed [sis_pkg::VALUE_W-1:0]   left_value,
   input  logic signed [sis_pkg::VALUE_W-1:0]   right_value,
   output logic                                 gt,
   output logic signed [sis_pkg::VALUE_W-1:0]   value
);

   logic signed [sis_pkg::VALUE_W-1:0] value_ff;
   logic signed [sis_pkg::VALUE_W-1:0] value_in;

   // An empty slot or a larger stored value lies at or behind the insert point.
   assign gt    = !occupied || (value_ff > ctl.value);
   assign value = value_ff;

   // Next slot contents.
   always_comb begin
      value_in = value_ff;
      if (ctl.push) begin
         if (left_gt) begin
            value_in = left_value;
         end else if (gt) begin
            value_in = ctl.value;
         end
      end else if (ctl.pop) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== hw/rtl/sorted_insert_stack.sv =====
// Sorted insert stack: a bounded store of signed 32-bit values kept in
// ascending order with the smallest value on top.
// The request channel carries an action (push, pop, peek, or no-op) and a
// value used by push. The response channel returns one item per request:
// the top value for pop and peek (-1 when empty), a was_empty flag, a
// dropped flag for a push into a full store, and the entry count afterwards.
// The response is registered: a request accepted at a clock edge has its
// response valid from that edge on. Throughput is one request per cycle
// while the receiver takes each response; the chain of cells updates every
// slot in parallel, so each request finishes in the cycle it is accepted,
// with the entry count and the top cell feeding the registered response.
// When the receiver stalls, the response register holds its item and a new
// request is accepted only in a cycle where the held response is taken.
// Reset empties the store and clears the response valid; slot contents are
// not cleared, since only slots below the entry count are ever read.
module sorted_insert_stack #(
   parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
   input  logic     clock,
   input  logic     reset,
   sis_req_if.sink  req_ch,
   sis_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic signed [sis_pkg::VALUE_W-1:0] result_ff;
   logic signed [sis_pkg::VALUE_W-1:0] result_in;
   logic              was_empty_ff;
   logic              dropped_ff;
   logic              dropped_in;

   logic              fire;
   logic              empty;
   logic              full;
   sis_pkg::cell_ctl_type ctl;

   logic signed [sis_pkg::VALUE_W-1:0] cell_value [CAPACITY];
   logic                               cell_gt    [CAPACITY];

   // Handshake: take a request whenever the response register is free or its item is being taken.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;
   assign empty        = (count_ff == '0);
   assign full         = (count_ff == CNT_W'(CAPACITY));

   // Control for the chain.
   always_comb begin
      ctl.push  = fire && (req_ch.action == sis_pkg::ACT_PUSH) && !full;
      ctl.pop   = fire && (req_ch.action == sis_pkg::ACT_POP) && !empty;
      ctl.value = req_ch.value;
   end

   // Chain of cells; slot 0 is the top.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                               occupied;
      logic                               left_gt;
      logic signed [sis_pkg::VALUE_W-1:0] left_value;
      logic signed [sis_pkg::VALUE_W-1:0] right_value;

      assign occupied = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_first
         assign left_gt    = 1'b0;
         assign left_value = req_ch.value;
      end else begin : g_inner
         assign left_gt    = cell_gt[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      sis_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occupied),
         .left_gt     (left_gt),
         .left_value  (left_value),
         .right_value (right_value),
         .gt          (cell_gt[i]),
         .value       (cell_value[i])
      );
   end

   // Response contents and next entry count.
   always_comb begin
      count_in   = count_ff;
      result_in  = '0;
      dropped_in = 1'b0;
      unique case (req_ch.action)
         sis_pkg::ACT_PUSH: begin
            dropped_in = full;
            if (!full) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         sis_pkg::ACT_POP: begin
            result_in = empty ? sis_pkg::EMPTY_VALUE : cell_value[0];
            if (!empty) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         sis_pkg::ACT_PEEK: begin
            result_in = empty ? sis_pkg::EMPTY_VALUE : cell_value[0];
         end
         default: begin
            result_in = '0;
         end
      endcase
   end

   // Response valid: set by a request, cleared once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff    <= result_in;
         was_empty_ff <= empty;
         dropped_ff   <= dropped_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = result_ff;
   assign rsp_ch.was_empty    = was_empty_ff;
   assign rsp_ch.dropped      = dropped_ff;
   assign rsp_ch.entry_count  = sis_pkg::COUNT_W'(count_ff);

endmodule

// ===== hw/rtl/sis_checker.sv =====
`include "sorted_insert_stack_assert.svh"

// Port-level checks on the response stream of the sorted insert stack.
module sis_checker #(
   parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [sis_pkg::VALUE_W-1:0] rsp_result_value,
   input logic                               rsp_was_empty,
   input logic                               rsp_dropped,
   input logic [sis_pkg::COUNT_W-1:0]        rsp_entry_count
);

   logic stalled;
   logic drop_full;

   assign stalled   = rsp_valid && !rsp_ready;
   assign drop_full = (rsp_entry_count == sis_pkg::COUNT_W'(CAPACITY)) && !rsp_was_empty;

   // A stalled response holds its value.
   `SIS_ASSERT_NEXT(a_hold, clock, reset, stalled, rsp_valid && $stable(rsp_result_value))

   // A dropped push only happens on a full, hence nonempty, store.
   `SIS_ASSERT_NOW(a_drop_full, clock, reset, rsp_valid && rsp_dropped, drop_full)

   // Starting from empty, at most one entry can be present afterwards.
   `SIS_ASSERT_NOW(a_empty_cnt, clock, reset, rsp_valid && rsp_was_empty, rsp_entry_count <= 5'd1)

endmodule

bind sorted_insert_stack sis_checker #(.CAPACITY(CAPACITY)) u_sis_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_was_empty    (rsp_ch.was_empty),
   .rsp_dropped      (rsp_ch.dropped),
   .rsp_entry_count  (rsp_ch.entry_count)
);

// ===== tb/sorted_insert_stack_tb.sv =====
`timescale 1ns / 100ps

module sorted_insert_stack_tb;

   localparam int SHELF_DEPTH  = sis_pkg::CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 700;
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic signed [sis_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [sis_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   // One response as the block reports it.
   typedef struct packed {
      logic signed [sis_pkg::VALUE_W-1:0] top;
      logic                               was_empty;
      logic                               dropped;
      logic [sis_pkg::COUNT_W-1:0]        count;
   } outcome_type;

   // One row of the directed table; typed rows carry a hand-written outcome.
   typedef struct {
      logic [sis_pkg::ACTION_W-1:0]       action;
      logic signed [sis_pkg::VALUE_W-1:0] value;
      bit                                 typed;
      outcome_type                        outcome;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   sis_req_if req_ch ();
   sis_rsp_if rsp_ch ();

   sorted_insert_stack #(.CAPACITY(SHELF_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Mirror of the sorted store, smallest value at index 0.
   logic signed [sis_pkg::VALUE_W-1:0] shelf[$];
   outcome_type                        pending_outcomes[$];
   plan_row_type                       plan[$];

   int  error_count   = 0;
   int  cycle_count   = 0;
   int  checked_count = 0;
   int  push_count    = 0;
   int  pop_count     = 0;
   int  peek_count    = 0;
   int  nop_count     = 0;
   int  refused_count = 0;
   int  empty_hits    = 0;
   int  deepest_fill  = 0;
   int  ready_run     = 0;
   bit  quiet_sender  = 1'b0;

   // Free-running clock, 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  pending_outcomes.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Applies one request to the mirrored store and returns its outcome.
   function automatic outcome_type apply_to_shelf(
         input logic [sis_pkg::ACTION_W-1:0] action,
         input logic signed [sis_pkg::VALUE_W-1:0] value);
      outcome_type result;
      int          slot;
      result = '0;
      result.was_empty = (shelf.size() == 0);
      case (action)
         sis_pkg::ACT_PUSH: begin
            if (shelf.size() >= SHELF_DEPTH) begin
               result.dropped = 1'b1;
            end else begin
               // Equal values stay ahead of the newcomer.
               slot = 0;
               while (slot < shelf.size() && shelf[slot] <= value) slot++;
               shelf.insert(slot, value);
            end
         end
         sis_pkg::ACT_POP, sis_pkg::ACT_PEEK: begin
            if (result.was_empty) begin
               result.top = sis_pkg::EMPTY_VALUE;
            end else begin
               result.top = shelf[0];
               if (action == sis_pkg::ACT_POP) void'(shelf.pop_front());
            end
         end
         default: ;
      endcase
      result.count = sis_pkg::COUNT_W'(shelf.size());
      return result;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [sis_pkg::VALUE_W-1:0] pick_value(input int mode);
      logic signed [sis_pkg::VALUE_W-1:0] corner[6];
      corner = '{VAL_MIN, VAL_MIN + 1, -1, 0, VAL_MAX - 1, VAL_MAX};
      case (mode)
         0:       return $signed($urandom_range(0, 16)) - 8;
         1:       return $urandom;
         default: return corner[$urandom_range(0, 5)];
      endcase
   endfunction

   task automatic add_row(input logic [sis_pkg::ACTION_W-1:0] action,
                          input logic signed [sis_pkg::VALUE_W-1:0] value,
                          input bit typed,
                          input logic signed [sis_pkg::VALUE_W-1:0] top,
                          input logic was_empty, input logic dropped,
                          input int count);
      plan_row_type row;
      row.action  = action;
      row.value   = value;
      row.typed   = typed;
      row.outcome = '{top: top, was_empty: was_empty, dropped: dropped,
                      count: count[sis_pkg::COUNT_W-1:0]};
      plan.push_back(row);
   endtask

   // Drives one request, waits for acceptance and records its outcome.
   task automatic send_request(input logic [sis_pkg::ACTION_W-1:0] action,
                               input logic signed [sis_pkg::VALUE_W-1:0] value,
                               input bit typed, input outcome_type typed_outcome);
      outcome_type predicted;
      int          idle;
      idle = quiet_sender ? 0 : pick_gap();
      if (idle > 0) begin
         req_ch.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= action;
      req_ch.value  <= value;
      do @(posedge clock); while (!req_ch.ready);

      predicted = apply_to_shelf(action, value);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
      case (action)
         sis_pkg::ACT_PUSH: push_count++;
         sis_pkg::ACT_POP:  pop_count++;
         sis_pkg::ACT_PEEK: peek_count++;
         default:           nop_count++;
      endcase
      if (predicted.dropped) refused_count++;
      if (predicted.was_empty &&
          (action == sis_pkg::ACT_POP || action == sis_pkg::ACT_PEEK)) empty_hits++;
      if (shelf.size() > deepest_fill) deepest_fill = shelf.size();
   endtask

   // Response side: check each accepted response and stall at random.
   always @(posedge clock) begin : rsp_side
      outcome_type want;
      outcome_type seen;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = '{top: rsp_ch.result_value, was_empty: rsp_ch.was_empty,
                     dropped: rsp_ch.dropped, count: rsp_ch.entry_count};
            if (pending_outcomes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response value=%0d empty=%0b dropped=%0b count=%0d",
                        $time, seen.top, seen.was_empty, seen.dropped, seen.count);
            end else begin
               want = pending_outcomes.pop_front();
               checked_count++;
               if (seen.top !== want.top || seen.was_empty !== want.was_empty ||
                   seen.dropped !== want.dropped || seen.count !== want.count) begin
                  error_count++;
                  $display("%0t: mismatch expected value=%0d empty=%0b dropped=%0b count=%0d",
                           $time, want.top, want.was_empty, want.dropped, want.count);
                  $display("%0t:          actual   value=%0d empty=%0b dropped=%0b count=%0d",
                           $time, seen.top, seen.was_empty, seen.dropped, seen.count);
               end
            end
         end
         if (ready_run == 0) begin
            if ($urandom_range(0, 3) != 0) begin
               rsp_ch.ready <= 1'b1;
               ready_run = $urandom_range(1, 40);
            end else begin
               rsp_ch.ready <= 1'b0;
               ready_run = pick_gap();
            end
         end else begin
            ready_run--;
         end
      end
   end

   // Request side: reset, directed table, random segments, drain.
   initial begin : req_side
      logic [sis_pkg::ACTION_W-1:0]       action;
      logic signed [sis_pkg::VALUE_W-1:0] value;
      int                                 sent_random;
      int                                 seg_len;
      int                                 push_pct;
      int                                 value_mode;
      int                                 roll;

      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.action <= sis_pkg::ACT_NOP;
      req_ch.value  <= '0;

      // Empty store, both extremes, then fill to capacity and overflow.
      add_row(sis_pkg::ACT_PEEK, 0,       1'b1, sis_pkg::EMPTY_VALUE, 1'b1, 1'b0, 0);
      add_row(sis_pkg::ACT_POP,  VAL_MAX, 1'b1, sis_pkg::EMPTY_VALUE, 1'b1, 1'b0, 0);
      add_row(sis_pkg::ACT_NOP,  VAL_MAX, 1'b1, 0,       1'b1, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, VAL_MIN, 1'b1, 0,       1'b1, 1'b0, 1);
      add_row(sis_pkg::ACT_PUSH, VAL_MAX, 1'b1, 0,       1'b0, 1'b0, 2);
      add_row(sis_pkg::ACT_PEEK, -1,      1'b1, VAL_MIN, 1'b0, 1'b0, 2);
      add_row(sis_pkg::ACT_PUSH, 0,       1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, -1,      1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, 5,       1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, 5,       1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, -5,      1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, VAL_MAX, 1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, VAL_MIN, 1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, 1,       1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, -2,      1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, 100,     1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, -100,    1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, 3,       1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, 3,       1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, 42,      1'b0, 0, 1'b0, 1'b0, 0);
      add_row(sis_pkg::ACT_PUSH, 7,       1'b1, 0,       1'b0, 1'b1, SHELF_DEPTH);
      add_row(sis_pkg::ACT_NOP,  -1,      1'b1, 0,       1'b0, 1'b0, SHELF_DEPTH);
      add_row(sis_pkg::ACT_POP,  0,       1'b1, VAL_MIN, 1'b0, 1'b0, SHELF_DEPTH - 1);
      add_row(sis_pkg::ACT_POP,  0,       1'b1, VAL_MIN, 1'b0, 1'b0, SHELF_DEPTH - 2);
      add_row(sis_pkg::ACT_PEEK, 0,       1'b0, 0, 1'b0, 1'b0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_request(plan[i].action, plan[i].value, plan[i].typed,
                                     plan[i].outcome);

      // Random segments, each with its own push bias and value style so the
      // store swings between empty and full.
      sent_random = 0;
      while (sent_random < RANDOM_ITEMS) begin
         seg_len = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0:       push_pct = 85;
            1:       push_pct = 50;
            default: push_pct = 20;
         endcase
         value_mode   = $urandom_range(0, 2);
         quiet_sender = ($urandom_range(0, 4) == 0);
         for (int k = 0; k < seg_len && sent_random < RANDOM_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
               action = sis_pkg::ACT_PUSH;
            end else begin
               case ($urandom_range(0, 9))
                  0:             action = sis_pkg::ACT_NOP;
                  1, 2, 3, 4:    action = sis_pkg::ACT_PEEK;
                  default:       action = sis_pkg::ACT_POP;
               endcase
            end
            value = ($urandom_range(0, 9) == 0) ? pick_value($urandom_range(0, 2))
                                                : pick_value(value_mode);
            send_request(action, value, 1'b0, '0);
            sent_random++;
         end
      end
      quiet_sender = 1'b0;
      req_ch.valid <= 1'b0;

      // Drain, then keep the clock running for anything stray.
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d requests: %0d push, %0d pop, %0d peek, %0d no-op; %0d checked.",
               push_count + pop_count + peek_count + nop_count, push_count, pop_count,
               peek_count, nop_count, checked_count);
      $display("Pushes refused on a full store: %0d; pop or peek on empty: %0d; peak fill %0d.",
               refused_count, empty_hits, deepest_fill);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sorted_insert_stack.f =====
+incdir+hw/rtl
hw/rtl/sis_pkg.sv
hw/rtl/sis_if.sv
hw/rtl/sis_cell.sv
hw/rtl/sorted_insert_stack.sv
hw/rtl/sis_checker.sv
tb/sorted_insert_stack_tb.sv
